[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every sampled edge.
`define CHK_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// When the antecedent holds, the consequent must hold at the same edge.
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define CHK_ALWAYS(lbl, cond)
`define CHK_IMPLY(lbl, ante, cons)
`endif
`endif

[sv/dfd_pkg.sv]
// ----------------------------------------------------------------------------
// dfd_pkg: shared types and constants of the binary64 to decimal converter
// Status codes, the queue entry layout, the back-end states and powers of ten.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfd_pkg;

    localparam int DEFAULT_MAX_PLACES = 12;

    localparam logic [2:0] ST_VALID = 3'd0;
    localparam logic [2:0] ST_NAN   = 3'd1;
    localparam logic [2:0] ST_PINF  = 3'd2;
    localparam logic [2:0] ST_NINF  = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    localparam logic [62:0] WHOLE_LIMIT = 63'd9000000000000000000;

    // One classified request waiting for digit generation.
    // The fraction is frac_m * 2^-frac_s, always below 2^53 in frac_m.
    typedef struct packed {
        logic [63:0] bits;
        logic [4:0]  places;
        logic [2:0]  status;
        logic        neg;
        logic [62:0] whole;
        logic [52:0] frac_m;
        logic [10:0] frac_s;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCALE,
        BK_EXTRACT,
        BK_ROUND
    } back_state_t;

    // Ten to the power of n for n up to 19.
    function automatic logic [63:0] pow10(input logic [4:0] n);
        logic [63:0] r;
        case (n)
            5'd0:  r = 64'd1;
            5'd1:  r = 64'd10;
            5'd2:  r = 64'd100;
            5'd3:  r = 64'd1000;
            5'd4:  r = 64'd10000;
            5'd5:  r = 64'd100000;
            5'd6:  r = 64'd1000000;
            5'd7:  r = 64'd10000000;
            5'd8:  r = 64'd100000000;
            5'd9:  r = 64'd1000000000;
            5'd10: r = 64'd10000000000;
            5'd11: r = 64'd100000000000;
            5'd12: r = 64'd1000000000000;
            5'd13: r = 64'd10000000000000;
            5'd14: r = 64'd100000000000000;
            5'd15: r = 64'd1000000000000000;
            5'd16: r = 64'd10000000000000000;
            5'd17: r = 64'd100000000000000000;
            5'd18: r = 64'd1000000000000000000;
            5'd19: r = 64'd10000000000000000000;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/dfd_front.sv]
// ----------------------------------------------------------------------------
// dfd_front: request intake and classification
// Saturates the place count, sorts out NaN, infinities and large values, and
// splits finite values into a whole part and an exact binary fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfd_front
    import dfd_pkg::*;
#(
    parameter int MAX_PLACES = DEFAULT_MAX_PLACES
)
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        q_full,
    output logic             push,
    output item_t            entry
);

    localparam logic [4:0] MAX_P = 5'(MAX_PLACES);

    logic [63:0] bits;
    logic [4:0]  req_places;
    logic [10:0] exp_f;
    logic [51:0] man_f;
    logic [52:0] sig;
    logic [10:0] e_unb;
    logic [10:0] sh_r;
    logic [3:0]  sh_l;
    logic [62:0] whole;

    assign bits       = s_tdata[63:0];
    assign req_places = s_tdata[68:64];
    assign exp_f      = bits[62:52];
    assign man_f      = bits[51:0];
    assign sig        = {(exp_f != 11'd0), man_f};
    assign e_unb      = (exp_f == 11'd0) ? 11'd1 : exp_f;
    assign sh_r       = 11'd1075 - e_unb;
    assign sh_l       = 4'(e_unb - 11'd1075);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Classification and whole/fraction split.
    always_comb
    begin
        entry.bits   = bits;
        entry.places = (req_places > MAX_P) ? MAX_P : req_places;
        entry.neg    = bits[63];
        entry.status = ST_VALID;
        entry.frac_m = 53'd0;
        entry.frac_s = 11'd0;
        whole        = 63'd0;
        if (exp_f == 11'h7FF)
        begin
            if (man_f != 52'd0)
                entry.status = ST_NAN;
            else
                entry.status = bits[63] ? ST_NINF : ST_PINF;
        end
        else if (e_unb >= 11'd1086)
        begin
            entry.status = ST_RANGE;
        end
        else if (e_unb >= 11'd1075)
        begin
            whole = {10'd0, sig} << sh_l;
        end
        else
        begin
            if (sh_r >= 11'd53)
            begin
                entry.frac_m = sig;
            end
            else
            begin
                whole        = 63'(sig >> sh_r);
                entry.frac_m = sig & ((53'd1 << sh_r) - 53'd1);
            end
            entry.frac_s = sh_r;
        end
        if (entry.status == ST_VALID && whole > WHOLE_LIMIT)
            entry.status = ST_RANGE;
        entry.whole = whole;
    end

endmodule

`default_nettype wire

[sv/dfd_queue.sv]
// ----------------------------------------------------------------------------
// dfd_queue: two-entry queue between intake and digit generation
// Lets the front accept a new request while the back end is still busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfd_queue
    import dfd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t entry_in,
    input  wire logic  pop,
    output item_t      entry_out,
    output logic       full,
    output logic       empty
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign entry_out = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry_in;
    end

endmodule

`default_nettype wire

[sv/dfd_back.sv]
// ----------------------------------------------------------------------------
// dfd_back: decimal digit generation and rounding
// Draws each digit by a rounded multiply-by-ten and a split,
// then applies the guard digit and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfd_back
    import dfd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire item_t q_entry,
    output logic       pop,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [62:0] out_whole,
    output logic [63:0] out_frac,
    output logic [4:0]  out_places,
    output logic        out_neg,
    output logic [2:0]  out_status,
    output logic [63:0] out_bits
);

    back_state_t state_reg, state_next;

    logic [62:0] whole_reg;
    logic [52:0] m_reg;
    logic [10:0] s_reg;
    logic [4:0]  places_reg;
    logic        neg_reg;
    logic [2:0]  status_reg;
    logic [63:0] bits_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [3:0]  guard_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic        load_out;

    // Rounded multiply-by-ten signals.
    logic [56:0] prod;
    logic [2:0]  k;
    logic [56:0] q;
    logic [56:0] rbits;
    logic [56:0] halfway;
    logic        up;
    logic [56:0] q_rnd;
    logic [52:0] sc_m;
    logic [10:0] sc_s;

    // Digit split signals.
    logic [52:0] d_raw;
    logic [3:0]  dig;
    logic [52:0] ex_m;
    logic [10:0] ex_s;

    // Rounding signals.
    logic        inc;
    logic [63:0] acc_p1;
    logic        carry;
    logic [63:0] dig_f;
    logic [62:0] whole_f;
    logic [2:0]  status_f;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // Multiply the fraction by ten and round back to 53 bits, nearest even.
    always_comb
    begin
        prod = {1'b0, m_reg, 3'b000} + {3'b000, m_reg, 1'b0};
        if (prod[56])
            k = 3'd4;
        else if (prod[55])
            k = 3'd3;
        else if (prod[54])
            k = 3'd2;
        else if (prod[53])
            k = 3'd1;
        else
            k = 3'd0;
        q       = prod >> k;
        rbits   = prod & ((57'd1 << k) - 57'd1);
        halfway = (k == 3'd0) ? 57'd0 : (57'd1 << (k - 3'd1));
        up      = (k != 3'd0) && ((rbits > halfway) || ((rbits == halfway) && q[0]));
        q_rnd   = q + {56'd0, up};
        if (q_rnd[53])
        begin
            sc_m = q_rnd[53:1];
            sc_s = s_reg - {8'd0, k} - 11'd1;
        end
        else
        begin
            sc_m = q_rnd[52:0];
            sc_s = s_reg - {8'd0, k};
        end
    end

    // Split off the integer digit; a value of ten saturates to nine and one.
    always_comb
    begin
        ex_m = m_reg;
        ex_s = s_reg;
        if (s_reg >= 11'd53)
        begin
            d_raw = 53'd0;
        end
        else
        begin
            d_raw = m_reg >> s_reg;
            ex_m  = m_reg & ((53'd1 << s_reg) - 53'd1);
        end
        if (d_raw >= 53'd10)
        begin
            dig  = 4'd9;
            ex_m = 53'd1;
            ex_s = 11'd0;
        end
        else
        begin
            dig = d_raw[3:0];
        end
    end

    // Guard-digit rounding, carry into the whole part and final range check.
    always_comb
    begin
        inc      = (guard_reg >= 4'd5);
        acc_p1   = acc_reg + 64'd1;
        carry    = inc && (acc_p1 == pow10(places_reg));
        dig_f    = inc ? (carry ? 64'd0 : acc_p1) : acc_reg;
        whole_f  = whole_reg + {62'd0, carry};
        status_f = status_reg;
        if (status_reg == ST_VALID && whole_f > WHOLE_LIMIT)
            status_f = ST_RANGE;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                    state_next = (q_entry.status == ST_VALID) ? BK_SCALE : BK_ROUND;
            end
            BK_SCALE:
            begin
                state_next = BK_EXTRACT;
            end
            BK_EXTRACT:
            begin
                state_next = (cnt_reg == places_reg) ? BK_ROUND : BK_SCALE;
            end
            BK_ROUND:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:    pop      = !q_empty;
            BK_ROUND:   load_out = out_free;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            whole_reg  <= q_entry.whole;
            m_reg      <= q_entry.frac_m;
            s_reg      <= q_entry.frac_s;
            places_reg <= q_entry.places;
            neg_reg    <= q_entry.neg;
            status_reg <= q_entry.status;
            bits_reg   <= q_entry.bits;
            cnt_reg    <= 5'd0;
            acc_reg    <= 64'd0;
            guard_reg  <= 4'd0;
        end
        else if (state_reg == BK_SCALE)
        begin
            m_reg <= sc_m;
            s_reg <= sc_s;
        end
        else if (state_reg == BK_EXTRACT)
        begin
            m_reg   <= ex_m;
            s_reg   <= ex_s;
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg < places_reg)
                acc_reg <= (acc_reg << 3) + (acc_reg << 1) + {60'd0, dig};
            else
                guard_reg <= dig;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_places <= places_reg;
            out_bits   <= bits_reg;
            out_status <= status_f;
            if (status_f == ST_VALID)
            begin
                out_whole <= whole_f;
                out_frac  <= dig_f;
                out_neg   <= neg_reg && ((whole_f != 63'd0) || (dig_f != 64'd0));
            end
            else
            begin
                out_whole <= 63'd0;
                out_frac  <= 64'd0;
                out_neg   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[sv/double_to_fixed_decimal.sv]
// ----------------------------------------------------------------------------
// double_to_fixed_decimal: binary64 to decimal fixed-point converter
// Turns raw binary64 bits into a whole part, rounded fraction digits,
// a sign flag and a status.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata: value_bits, requested_places
// m_*       out  m_tvalid/m_tready   tdata: result fields, tuser: conv_status
//
// In the back end a request with p places (after saturation) is picked up in
// IDLE; SCALE (rounded multiply-by-ten) and EXTRACT (digit split) draw each
// digit plus guard, and ROUND rounds it once the result register is free.
// NaN, infinities and large values skip digit generation and go to ROUND.
// A two-entry queue lets intake continue while digits are drawn; the result
// register holds one finished result. Reset is asynchronous and clears the
// queue, the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module double_to_fixed_decimal
    import dfd_pkg::*;
#(
    parameter int MAX_PLACES = DEFAULT_MAX_PLACES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [63:0] value_bits, [68:64] requested_places, [71:69] zero
    input  wire logic [71:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [62:0] whole_part, [126:63] fraction_digits, [131:127] places_used,
    // [132] is_negative, [196:133] echo_bits, [199:197] zero
    output logic [199:0]      m_tdata,
    // [2:0] conv_status
    output logic [2:0]        m_tuser
);

    item_t       f_entry;
    item_t       q_entry;
    logic        f_push;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic [62:0] r_whole;
    logic [63:0] r_frac;
    logic [4:0]  r_places;
    logic        r_neg;
    logic [2:0]  r_status;
    logic [63:0] r_bits;

    dfd_front #(
        .MAX_PLACES (MAX_PLACES)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (f_push),
        .entry    (f_entry)
    );

    dfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .entry_in  (f_entry),
        .pop       (q_pop),
        .entry_out (q_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    dfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_entry    (q_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_whole  (r_whole),
        .out_frac   (r_frac),
        .out_places (r_places),
        .out_neg    (r_neg),
        .out_status (r_status),
        .out_bits   (r_bits)
    );

    // Pack the result fields.
    assign m_tdata = {3'd0, r_bits, r_neg, r_places, r_frac, r_whole};
    assign m_tuser = r_status;

    // A result that is not valid carries no magnitude and no sign.
    `CHK_IMPLY(a_invalid_zero, m_tvalid && (r_status != ST_VALID),
               (r_whole == 63'd0) && (r_frac == 64'd0) && !r_neg)
    // The places applied never exceed the configured limit.
    `CHK_IMPLY(a_places_max, m_tvalid, r_places <= 5'(MAX_PLACES))
    // Fraction digits stay below ten to the power of the places used.
    `CHK_IMPLY(a_frac_range, m_tvalid, r_frac < pow10(r_places))
    // The queue never reports full and empty together.
    `CHK_ALWAYS(a_queue_sane, !(q_full && q_empty))

endmodule

`default_nettype wire
